// ----- hdl/qrm_pkg.sv -----
package qrm_pkg;

    localparam int unsigned IN_W    = 16;
    localparam int unsigned PROD_W  = 32;
    localparam int unsigned SUM_W   = 35;
    localparam int unsigned NORM_W  = 33;
    localparam int unsigned REM_W   = 34;
    localparam int unsigned QUO_W   = 16;
    localparam int unsigned OUT_W   = 16;
    localparam int unsigned N_LANE  = 9;
    localparam int unsigned N_CELL  = QUO_W;
    localparam logic [QUO_W-1:0] ONE_Q14 = QUO_W'(16384);

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             lsb;
        logic             neg;
    } t_lane;

    typedef struct packed {
        logic                    valid;
        logic                    zero;
        logic [NORM_W-1:0]       norm;
        t_lane [N_LANE-1:0]      lane;
    } t_beat;

endpackage

// ----- hdl/qrm_front.sv -----
module qrm_front
    import qrm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_ce,
    input  logic                    i_valid,
    input  logic signed [IN_W-1:0]  i_x,
    input  logic signed [IN_W-1:0]  i_y,
    input  logic signed [IN_W-1:0]  i_z,
    input  logic signed [IN_W-1:0]  i_w,
    output t_beat                   o_beat
);

    logic                     r_vld;
    logic signed [PROD_W-1:0] r_xx, r_yy, r_zz, r_ww, r_xy, r_zw, r_xz, r_yw, r_yz, r_xw;
    t_beat                    r_beat;
    t_beat                    n_beat;

    logic signed [SUM_W-1:0]  e_xx, e_yy, e_zz, e_ww, e_xy, e_zw, e_xz, e_yw, e_yz, e_xw;
    logic signed [SUM_W-1:0]  w_num [N_LANE];
    logic signed [SUM_W-1:0]  w_abs [N_LANE];
    logic        [SUM_W-1:0]  w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ce) begin
            r_vld <= i_valid;
        end
        if (i_ce) begin
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_zz <= i_z * i_z;
            r_ww <= i_w * i_w;
            r_xy <= i_x * i_y;
            r_zw <= i_z * i_w;
            r_xz <= i_x * i_z;
            r_yw <= i_y * i_w;
            r_yz <= i_y * i_z;
            r_xw <= i_x * i_w;
        end
    end

    always_comb begin
        e_xx = SUM_W'(r_xx);
        e_yy = SUM_W'(r_yy);
        e_zz = SUM_W'(r_zz);
        e_ww = SUM_W'(r_ww);
        e_xy = SUM_W'(r_xy);
        e_zw = SUM_W'(r_zw);
        e_xz = SUM_W'(r_xz);
        e_yw = SUM_W'(r_yw);
        e_yz = SUM_W'(r_yz);
        e_xw = SUM_W'(r_xw);
        w_num[0] = e_xx - e_yy - e_zz + e_ww;
        w_num[1] = (e_xy - e_zw) <<< 1;
        w_num[2] = (e_xz + e_yw) <<< 1;
        w_num[3] = (e_xy + e_zw) <<< 1;
        w_num[4] = e_yy - e_xx - e_zz + e_ww;
        w_num[5] = (e_yz - e_xw) <<< 1;
        w_num[6] = (e_xz - e_yw) <<< 1;
        w_num[7] = (e_yz + e_xw) <<< 1;
        w_num[8] = e_zz - e_xx - e_yy + e_ww;
        w_sum    = SUM_W'(e_xx + e_yy + e_zz + e_ww);
        n_beat.valid = r_vld;
        n_beat.norm  = w_sum[NORM_W-1:0];
        n_beat.zero  = (w_sum == '0);
        for (int i = 0; i < N_LANE; i++) begin
            w_abs[i] = w_num[i][SUM_W-1] ? -w_num[i] : w_num[i];
            n_beat.lane[i].rem = REM_W'(w_abs[i][NORM_W-1:1]);
            n_beat.lane[i].lsb = w_abs[i][0];
            n_beat.lane[i].quo = '0;
            n_beat.lane[i].neg = w_num[i][SUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_ce) begin
            r_beat.valid <= n_beat.valid;
        end
        if (i_ce) begin
            r_beat.zero <= n_beat.zero;
            r_beat.norm <= n_beat.norm;
            r_beat.lane <= n_beat.lane;
        end
    end

    assign o_beat = r_beat;

endmodule

// ----- hdl/qrm_cell.sv -----
module qrm_cell
    import qrm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_ce,
    input  t_beat i_beat,
    output t_beat o_beat
);

    t_beat            r_beat;
    t_beat            n_beat;
    logic [REM_W-1:0] w_shift [N_LANE];
    logic             w_fit   [N_LANE];

    always_comb begin
        n_beat = i_beat;
        for (int i = 0; i < N_LANE; i++) begin
            w_shift[i] = {i_beat.lane[i].rem[REM_W-2:0], i_beat.lane[i].lsb};
            w_fit[i]   = (w_shift[i] >= REM_W'(i_beat.norm));
            n_beat.lane[i].rem = w_fit[i] ? w_shift[i] - REM_W'(i_beat.norm) : w_shift[i];
            n_beat.lane[i].quo = {i_beat.lane[i].quo[QUO_W-2:0], w_fit[i]};
            n_beat.lane[i].lsb = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_ce) begin
            r_beat.valid <= n_beat.valid;
        end
        if (i_ce) begin
            r_beat.zero <= n_beat.zero;
            r_beat.norm <= n_beat.norm;
            r_beat.lane <= n_beat.lane;
        end
    end

    assign o_beat = r_beat;

endmodule

// ----- hdl/quaternion_to_rotation_matrix.sv -----
// Quaternion to 3x3 rotation matrix, normalised by the squared norm.
// Input stream: one quaternion per beat on i_s_tdata, four signed Q1.14
// components x, y, z, w from the lowest bit up.
// Output stream: the nine matrix entries m00..m22 as signed Q1.14 on
// o_m_tdata, rounded to nearest with halves away from zero and clamped to
// plus or minus one; o_m_tuser flags an all-zero quaternion, whose entries
// are then all zero.
// The ten products are registered first, then the numerator and norm sums,
// then a row of sixteen divider cells that each settle one quotient bit of
// all nine entries, and the result is rounded into the output register.
// A new quaternion is taken in every cycle unless the output stalls.
// Reset clears every valid flag in the pipeline; data registers keep
// whatever they held.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_s_tready falls in the same cycle, so nothing is lost or repeated.
module quaternion_to_rotation_matrix
    import qrm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [4*IN_W-1:0]       i_s_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [N_LANE*OUT_W-1:0] o_m_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic                    o_m_tuser    // zero_norm
);

    logic                    w_ce;
    t_beat                   w_chain [N_CELL+1];
    logic                    r_valid;
    logic [N_LANE*OUT_W-1:0] r_data;
    logic                    r_zero;
    logic [N_LANE*OUT_W-1:0] n_data;
    logic [QUO_W:0]          w_inc  [N_LANE];
    logic [QUO_W-1:0]        w_mag  [N_LANE];

    assign w_ce       = !r_valid || i_m_tready;
    assign o_s_tready = w_ce;

    qrm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (i_s_tvalid),
        .i_x     (i_s_tdata[IN_W-1:0]),
        .i_y     (i_s_tdata[2*IN_W-1:IN_W]),
        .i_z     (i_s_tdata[3*IN_W-1:2*IN_W]),
        .i_w     (i_s_tdata[4*IN_W-1:3*IN_W]),
        .o_beat  (w_chain[0])
    );

    for (genvar g = 0; g < N_CELL; g++) begin : g_cell
        qrm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_beat  (w_chain[g]),
            .o_beat  (w_chain[g+1])
        );
    end

    always_comb begin
        for (int i = 0; i < N_LANE; i++) begin
            w_inc[i] = {1'b0, w_chain[N_CELL].lane[i].quo} + (QUO_W+1)'(1);
            w_mag[i] = (w_inc[i][QUO_W:1] > ONE_Q14) ? ONE_Q14 : w_inc[i][QUO_W:1];
            if (w_chain[N_CELL].zero) begin
                n_data[i*OUT_W +: OUT_W] = '0;
            end else if (w_chain[N_CELL].lane[i].neg) begin
                n_data[i*OUT_W +: OUT_W] = OUT_W'(-w_mag[i]);
            end else begin
                n_data[i*OUT_W +: OUT_W] = OUT_W'(w_mag[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ce) begin
            r_valid <= w_chain[N_CELL].valid;
        end
        if (w_ce) begin
            r_data <= n_data;
            r_zero <= w_chain[N_CELL].zero;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_zero;

    a_zero_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("zero_norm result carries non-zero entries");

    a_diag_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[OUT_W-1:0]) <= $signed(OUT_W'(ONE_Q14))
                     && $signed(o_m_tdata[OUT_W-1:0]) >= -$signed(OUT_W'(ONE_Q14))))
        else $error("m00 outside plus or minus one");

    a_hold_pipe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ce |=> ($stable(w_chain[N_CELL].valid) && $stable(w_chain[0].valid)))
        else $error("pipeline moved while the output was stalled");

endmodule
